// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the strided segment address generator RTL.
// Included by the modules that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ssag_pkg.sv -----
// Package for the strided segment address generator: types, register map,
// widths and dimension helper functions. No dependencies.
package ssag_pkg;

   localparam int MaxDimsDefault = 3;
   localparam int RegDims        = 3;
   localparam int AddrWidth      = 5;
   localparam int DataWidth      = 32;
   localparam int SizeWidth      = 16;
   localparam int StrideWidth    = 32;
   localparam int ElemWidth      = 48;
   localparam int ByteWidth      = 52;
   localparam int EbWidth        = 4;
   localparam int SettleWidth    = 2;

   localparam logic [SettleWidth-1:0] CfgSettleCycles = 2'd2;

   typedef enum logic [2:0] {
      REG_SIZE_OUTER    = 3'd0,
      REG_SIZE_MIDDLE   = 3'd1,
      REG_SIZE_INNER    = 3'd2,
      REG_STRIDE_OUTER  = 3'd3,
      REG_STRIDE_MIDDLE = 3'd4,
      REG_STRIDE_INNER  = 3'd5,
      REG_ELEMENT_BYTES = 3'd6,
      REG_BASE_OFFSET   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [SizeWidth-1:0]   size_outer;
      logic [SizeWidth-1:0]   size_middle;
      logic [SizeWidth-1:0]   size_inner;
      logic [StrideWidth-1:0] stride_outer;
      logic [StrideWidth-1:0] stride_middle;
      logic [StrideWidth-1:0] stride_inner;
      logic [EbWidth-1:0]     element_bytes;
      logic [StrideWidth-1:0] base_offset;
   } cfg_type;

   // Item between the product stage and the result register.
   typedef struct packed {
      logic [ElemWidth-1:0] src_elems;
      logic [ByteWidth-1:0] dst_elems;
      logic [ElemWidth-1:0] seg_elems;
      logic                 last;
   } stage_type;

   // A size of zero counts as one.
   function automatic logic [SizeWidth-1:0] size_eff(input logic [SizeWidth-1:0] s);
      logic [SizeWidth-1:0] r;
      r = (s == '0) ? SizeWidth'(1) : s;
      return r;
   endfunction

   // Dimension d counts from the innermost; dimensions past the registers are size one.
   function automatic logic [SizeWidth-1:0] dim_size(input cfg_type c, input int d);
      logic [SizeWidth-1:0] r;
      if (d == 0) begin
         r = size_eff(c.size_inner);
      end else if (d == 1) begin
         r = size_eff(c.size_middle);
      end else if (d == 2) begin
         r = size_eff(c.size_outer);
      end else begin
         r = SizeWidth'(1);
      end
      return r;
   endfunction

   function automatic logic [StrideWidth-1:0] dim_stride(input cfg_type c, input int d);
      logic [StrideWidth-1:0] r;
      if (d == 0) begin
         r = c.stride_inner;
      end else if (d == 1) begin
         r = c.stride_middle;
      end else if (d == 2) begin
         r = c.stride_outer;
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// ----- hdl/strided_segment_address_generator.sv -----
// An accepted item is registered in the product stage and then in the result register.
// Throughput: one item per cycle, except while req_stall is raised by the settling window or a stalled output.
// After reset and after every register write, items are held off while the
// dimension-merge products are recomputed.
// Reset: registers return to sizes 1, strides 1, element_bytes 4, base 0,
// and no walk is in progress, so the first item starts a new walk.
module strided_segment_address_generator #(
   parameter int MAX_DIMS = ssag_pkg::MaxDimsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ssag_pkg::AddrWidth-1:0] paddr,
   input  logic [ssag_pkg::DataWidth-1:0] pwdata,
   output logic [ssag_pkg::DataWidth-1:0] prdata,
   output logic                           pready,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ssag_pkg::ByteWidth-1:0] rsp_src_byte_offset,
   output logic [ssag_pkg::ByteWidth-1:0] rsp_dst_byte_offset,
   output logic [ssag_pkg::ByteWidth-1:0] rsp_segment_bytes,
   output logic                           rsp_last_segment
);
   import ssag_pkg::*;
   `include "assert_macros.svh"

   localparam int MergeW = $clog2(MAX_DIMS + 1);

   cfg_type              cfg;
   logic                 cfg_busy;
   logic [MergeW-1:0]    merge_count;
   logic [ElemWidth-1:0] merge_run;
   logic                 out_ready;
   logic                 stage_valid;
   stage_type            stage;

   ssag_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .cfg_busy (cfg_busy)
   );

   ssag_merge #(.MAX_DIMS(MAX_DIMS)) u_merge (
      .clock  (clock),
      .cfg    (cfg),
      .merged (merge_count),
      .run    (merge_run)
   );

   ssag_walk #(.MAX_DIMS(MAX_DIMS)) u_walk (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_busy    (cfg_busy),
      .merge_count (merge_count),
      .merge_run   (merge_run),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .out_ready   (out_ready),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   ssag_out u_out (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .stage_valid         (stage_valid),
      .stage               (stage),
      .out_ready           (out_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_src_byte_offset (rsp_src_byte_offset),
      .rsp_dst_byte_offset (rsp_dst_byte_offset),
      .rsp_segment_bytes   (rsp_segment_bytes),
      .rsp_last_segment    (rsp_last_segment)
   );

   `ASSERT_NEXT(a_write_holds_off_items, clock, reset, psel && penable && pwrite,
      req_stall, "item accepted while merge products were settling")
   `ASSERT_NEXT(a_stage_kept_on_stall, clock, reset, stage_valid && !out_ready,
      stage_valid, "product stage dropped an item while the output was stalled")

endmodule

// ----- hdl/ssag_csr.sv -----
// Configuration register file with APB-style access for the address generator.
// Depends on ssag_pkg. Flags a settling window after reset and after each write.
module ssag_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ssag_pkg::AddrWidth-1:0] paddr,
   input  logic [ssag_pkg::DataWidth-1:0] pwdata,
   output logic [ssag_pkg::DataWidth-1:0] prdata,
   output logic                           pready,
   output ssag_pkg::cfg_type              cfg,
   output logic                           cfg_busy
);
   import ssag_pkg::*;

   cfg_type                cfg_ff;
   logic [SettleWidth-1:0] settle_ff;
   logic                   wr;
   reg_index_type          idx;

   assign wr     = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[AddrWidth-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;
   assign cfg_busy = (settle_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_outer    <= SizeWidth'(1);
         cfg_ff.size_middle   <= SizeWidth'(1);
         cfg_ff.size_inner    <= SizeWidth'(1);
         cfg_ff.stride_outer  <= StrideWidth'(1);
         cfg_ff.stride_middle <= StrideWidth'(1);
         cfg_ff.stride_inner  <= StrideWidth'(1);
         cfg_ff.element_bytes <= EbWidth'(4);
         cfg_ff.base_offset   <= '0;
         settle_ff            <= CfgSettleCycles;
      end else begin
         if (wr) begin
            settle_ff <= CfgSettleCycles;
            unique case (idx)
               REG_SIZE_OUTER:    cfg_ff.size_outer    <= pwdata[SizeWidth-1:0];
               REG_SIZE_MIDDLE:   cfg_ff.size_middle   <= pwdata[SizeWidth-1:0];
               REG_SIZE_INNER:    cfg_ff.size_inner    <= pwdata[SizeWidth-1:0];
               REG_STRIDE_OUTER:  cfg_ff.stride_outer  <= pwdata[StrideWidth-1:0];
               REG_STRIDE_MIDDLE: cfg_ff.stride_middle <= pwdata[StrideWidth-1:0];
               REG_STRIDE_INNER:  cfg_ff.stride_inner  <= pwdata[StrideWidth-1:0];
               REG_ELEMENT_BYTES: cfg_ff.element_bytes <= pwdata[EbWidth-1:0];
               REG_BASE_OFFSET:   cfg_ff.base_offset   <= pwdata[StrideWidth-1:0];
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - SettleWidth'(1);
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_SIZE_OUTER:    prdata = DataWidth'(cfg_ff.size_outer);
         REG_SIZE_MIDDLE:   prdata = DataWidth'(cfg_ff.size_middle);
         REG_SIZE_INNER:    prdata = DataWidth'(cfg_ff.size_inner);
         REG_STRIDE_OUTER:  prdata = DataWidth'(cfg_ff.stride_outer);
         REG_STRIDE_MIDDLE: prdata = DataWidth'(cfg_ff.stride_middle);
         REG_STRIDE_INNER:  prdata = DataWidth'(cfg_ff.stride_inner);
         REG_ELEMENT_BYTES: prdata = DataWidth'(cfg_ff.element_bytes);
         REG_BASE_OFFSET:   prdata = DataWidth'(cfg_ff.base_offset);
      endcase
   end

endmodule

// ----- hdl/ssag_merge.sv -----
// Precomputes the coalescing of the innermost dimensions from the current
// configuration: number of merged dimensions and segment length in elements.
// Depends on ssag_pkg.
module ssag_merge #(
   parameter int MAX_DIMS = ssag_pkg::MaxDimsDefault
) (
   input  logic                                 clock,
   input  ssag_pkg::cfg_type                    cfg,
   output logic [$clog2(MAX_DIMS+1)-1:0]        merged,
   output logic [ssag_pkg::ElemWidth-1:0]       run
);
   import ssag_pkg::*;

   localparam int MergeW = $clog2(MAX_DIMS + 1);

   logic [SizeWidth-1:0]     s0, s1, s2;
   logic [2*SizeWidth-1:0]   p1_in, p1_ff;
   logic [ElemWidth-1:0]     p2;
   logic                     m0, m1, m2;
   logic [MergeW-1:0]        merged_in, merged_ff;
   logic [ElemWidth-1:0]     run_in, run_ff;

   assign s0 = size_eff(cfg.size_inner);
   assign s1 = size_eff(cfg.size_middle);
   assign s2 = size_eff(cfg.size_outer);

   assign p1_in = (2*SizeWidth)'(s0) * (2*SizeWidth)'(s1);
   assign p2    = ElemWidth'(p1_ff) * ElemWidth'(s2);

   assign m0 = (cfg.stride_inner == StrideWidth'(1));
   assign m1 = m0 && (MAX_DIMS >= 2) && (cfg.stride_middle == StrideWidth'(s0));
   assign m2 = m1 && (MAX_DIMS >= 3) && (cfg.stride_outer == StrideWidth'(p1_ff));

   assign merged_in = MergeW'(2'(m0) + 2'(m1) + 2'(m2));

   always_comb begin
      priority if (m2) begin
         run_in = p2;
      end else if (m1) begin
         run_in = ElemWidth'(p1_ff);
      end else if (m0) begin
         run_in = ElemWidth'(s0);
      end else begin
         run_in = ElemWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      p1_ff     <= p1_in;
      merged_ff <= merged_in;
      run_ff    <= run_in;
   end

   assign merged = merged_ff;
   assign run    = run_ff;

endmodule

// ----- hdl/ssag_walk.sv -----
// Walk state and odometer over the kept dimensions, plus the product stage that
// forms the source element offset. Depends on ssag_pkg and assert_macros.svh.
module ssag_walk #(
   parameter int MAX_DIMS = ssag_pkg::MaxDimsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssag_pkg::cfg_type                    cfg,
   input  logic                                 cfg_busy,
   input  logic [$clog2(MAX_DIMS+1)-1:0]        merge_count,
   input  logic [ssag_pkg::ElemWidth-1:0]       merge_run,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   input  logic                                 out_ready,
   output logic                                 stage_valid,
   output ssag_pkg::stage_type                  stage
);
   import ssag_pkg::*;
   `include "assert_macros.svh"

   localparam int MergeW  = $clog2(MAX_DIMS + 1);
   localparam int ProdDims = (MAX_DIMS < RegDims) ? MAX_DIMS : RegDims;

   logic [SizeWidth-1:0] idx_ff   [MAX_DIMS];
   logic [SizeWidth-1:0] idx_cur  [MAX_DIMS];
   logic [SizeWidth-1:0] idx_next [MAX_DIMS];
   logic                 active_ff;
   logic [MergeW-1:0]    merged_ff, merged_eff;
   logic [ElemWidth-1:0] seg_ff, seg_eff;
   logic [ByteWidth-1:0] acc_ff, acc_cur;
   logic                 begin_walk;
   logic                 last;
   logic                 stage_free;
   logic                 accept;
   logic [ElemWidth-1:0] off;
   stage_type            stage_ff;
   logic                 stage_valid_ff;

   assign stage_free = !stage_valid_ff || out_ready;
   assign req_stall  = cfg_busy || !stage_free;
   assign accept     = req_valid && !req_stall;

   assign begin_walk = req_restart || !active_ff;
   assign merged_eff = begin_walk ? merge_count : merged_ff;
   assign seg_eff    = begin_walk ? merge_run : seg_ff;
   assign acc_cur    = begin_walk ? '0 : acc_ff;

   always_comb begin
      logic                 carry;
      logic [SizeWidth:0]   nxt_wide;
      logic [SizeWidth-1:0] inc;
      last  = 1'b1;
      carry = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
         idx_cur[d] = begin_walk ? '0 : idx_ff[d];
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         nxt_wide    = (SizeWidth+1)'(idx_cur[d]) + (SizeWidth+1)'(1);
         inc         = nxt_wide[SizeWidth-1:0];
         idx_next[d] = idx_cur[d];
         if (d >= int'(merged_eff)) begin
            if (nxt_wide < (SizeWidth+1)'(dim_size(cfg, d))) begin
               last = 1'b0;
            end
            if (carry) begin
               if (inc >= dim_size(cfg, d)) begin
                  idx_next[d] = '0;
               end else begin
                  idx_next[d] = inc;
                  carry       = 1'b0;
               end
            end
         end
      end
   end

   // Digits of merged dimensions are always zero, so they add nothing here.
   always_comb begin
      off = '0;
      for (int d = 0; d < ProdDims; d++) begin
         off = off + ElemWidth'(idx_cur[d]) * ElemWidth'(dim_stride(cfg, d));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (stage_free) begin
            stage_valid_ff <= accept;
         end
         if (accept) begin
            active_ff <= !last;
         end
      end
      if (accept) begin
         merged_ff <= merged_eff;
         seg_ff    <= seg_eff;
         acc_ff    <= last ? acc_cur : acc_cur + ByteWidth'(seg_eff);
         for (int d = 0; d < MAX_DIMS; d++) begin
            idx_ff[d] <= last ? idx_cur[d] : idx_next[d];
         end
         stage_ff.src_elems <= off;
         stage_ff.dst_elems <= acc_cur;
         stage_ff.seg_elems <= seg_eff;
         stage_ff.last      <= last;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   `ASSERT_NEXT(a_last_ends_walk, clock, reset, accept && last, !active_ff,
      "walk still active after its last segment")
   `ASSERT_NEXT(a_first_step_advance, clock, reset, accept && begin_walk && !last,
      acc_ff == ByteWidth'(seg_ff), "first segment did not advance destination by one segment")

endmodule

// ----- hdl/ssag_out.sv -----
// Result register: scales element offsets and lengths to bytes and holds the
// item for the output channel. Depends on ssag_pkg.
module ssag_out (
   input  logic                           clock,
   input  logic                           reset,
   input  ssag_pkg::cfg_type              cfg,
   input  logic                           stage_valid,
   input  ssag_pkg::stage_type            stage,
   output logic                           out_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ssag_pkg::ByteWidth-1:0] rsp_src_byte_offset,
   output logic [ssag_pkg::ByteWidth-1:0] rsp_dst_byte_offset,
   output logic [ssag_pkg::ByteWidth-1:0] rsp_segment_bytes,
   output logic                           rsp_last_segment
);
   import ssag_pkg::*;

   logic                   rsp_valid_ff;
   logic [ElemWidth:0]     src_elems;
   logic [ByteWidth:0]     src_full;
   logic [ByteWidth+EbWidth-1:0] dst_full;
   logic [ByteWidth-1:0]   src_in, dst_in, seg_in;
   logic [ByteWidth-1:0]   src_ff, dst_ff, seg_ff;
   logic                   last_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   assign src_elems = (ElemWidth+1)'(cfg.base_offset) + (ElemWidth+1)'(stage.src_elems);
   assign src_full  = (ByteWidth+1)'(src_elems) * (ByteWidth+1)'(cfg.element_bytes);
   assign dst_full  = (ByteWidth+EbWidth)'(stage.dst_elems)
                    * (ByteWidth+EbWidth)'(cfg.element_bytes);
   assign src_in    = src_full[ByteWidth-1:0];
   assign dst_in    = dst_full[ByteWidth-1:0];
   assign seg_in    = ByteWidth'(stage.seg_elems) * ByteWidth'(cfg.element_bytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stage_valid;
      end
      if (out_ready && stage_valid) begin
         src_ff  <= src_in;
         dst_ff  <= dst_in;
         seg_ff  <= seg_in;
         last_ff <= stage.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_src_byte_offset = src_ff;
   assign rsp_dst_byte_offset = dst_ff;
   assign rsp_segment_bytes   = seg_ff;
   assign rsp_last_segment    = last_ff;

endmodule

// ----- tb/sv/strided_segment_address_generator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for strided_segment_address_generator: programs tensor shapes
// over the APB port, sends walk requests and checks every segment against its own predictor.
// Depends on ssag_pkg and the RTL of the block.
module strided_segment_address_generator_tb;
   import ssag_pkg::*;

   localparam int NumDims = MaxDimsDefault;
   localparam int WatchdogLimit = 2000;
   localparam int HoldCycles = 120;
   localparam bit [63:0] Mask48 = 64'hFFFF_FFFF_FFFF;
   localparam bit [63:0] Mask52 = 64'hF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [ByteWidth-1:0] src;
      logic [ByteWidth-1:0] dst;
      logic [ByteWidth-1:0] seg;
      logic                 last;
   } segment_desc_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ByteWidth-1:0] rsp_src_byte_offset;
   logic [ByteWidth-1:0] rsp_dst_byte_offset;
   logic [ByteWidth-1:0] rsp_segment_bytes;
   logic                 rsp_last_segment;

   // Shadow of the register file and of the walk state.
   cfg_type   walk_cfg;
   bit [15:0] digit [NumDims];
   bit [63:0] seg_elems = 64'd1;
   bit [63:0] seg_count = 64'd0;
   bit [63:0] src_elems = 64'd0;
   int        kept = 0;
   bit        walking = 1'b0;

   bit               pending_restarts [$];
   segment_desc_type expected_segments [$];
   int               tx_gap = 0;
   int               rx_gap = 0;
   bit               tx_idle_on = 1'b1;
   bit               rx_idle_on = 1'b1;
   bit               rx_hold = 1'b0;
   int               error_count = 0;
   int               quiet_cycles = 0;

   strided_segment_address_generator uut (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_src_byte_offset(rsp_src_byte_offset),
      .rsp_dst_byte_offset(rsp_dst_byte_offset),
      .rsp_segment_bytes(rsp_segment_bytes),
      .rsp_last_segment(rsp_last_segment)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [63:0] span_of(input int d);
      bit [15:0] s;
      case (d)
         0: s = walk_cfg.size_inner;
         1: s = walk_cfg.size_middle;
         2: s = walk_cfg.size_outer;
         default: s = 16'd1;
      endcase
      if (s == 16'd0) begin
         s = 16'd1;
      end
      return 64'(s);
   endfunction

   function automatic bit [63:0] pitch_of(input int d);
      bit [31:0] p;
      case (d)
         0: p = walk_cfg.stride_inner;
         1: p = walk_cfg.stride_middle;
         2: p = walk_cfg.stride_outer;
         default: p = 32'd0;
      endcase
      return 64'(p);
   endfunction

   // Computes the descriptor for one accepted item and advances the odometer.
   function automatic segment_desc_type predict_segment(input bit restart);
      segment_desc_type s;
      bit [63:0] run;
      bit [63:0] off;
      bit [63:0] nxt;
      bit [63:0] eb;
      int merged;
      int first;
      bit last;
      off = 64'd0;
      last = 1'b1;
      eb = 64'(walk_cfg.element_bytes);
      if (restart || !walking) begin
         run = 64'd1;
         merged = 0;
         while (merged < NumDims && pitch_of(merged) == run) begin
            run = (run * span_of(merged)) & Mask48;
            merged++;
         end
         seg_elems = run;
         kept = NumDims - merged;
         for (int d = 0; d < NumDims; d++) begin
            digit[d] = 16'd0;
         end
         src_elems = 64'd0;
         seg_count = 64'd0;
         walking = 1'b1;
      end
      first = NumDims - kept;
      for (int d = first; d < NumDims; d++) begin
         off = off + 64'(digit[d]) * pitch_of(d);
         if (64'(digit[d]) + 64'd1 < span_of(d)) begin
            last = 1'b0;
         end
      end
      src_elems = off & Mask48;
      s.src = ByteWidth'(((64'(walk_cfg.base_offset) + src_elems) * eb) & Mask52);
      s.dst = ByteWidth'((seg_count * seg_elems * eb) & Mask52);
      s.seg = ByteWidth'((seg_elems * eb) & Mask52);
      s.last = last;
      if (last) begin
         walking = 1'b0;
      end else begin
         for (int d = first; d < NumDims; d++) begin
            nxt = (64'(digit[d]) + 64'd1) & 64'hFFFF;
            if (nxt >= span_of(d)) begin
               digit[d] = 16'd0;
            end else begin
               digit[d] = nxt[15:0];
               break;
            end
         end
         seg_count = (seg_count + 64'd1) & Mask48;
      end
      return s;
   endfunction

   function automatic int draw_gap(input bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 65) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   task automatic report_error(input string msg);
      $display("%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DataWidth-1:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= AddrWidth'({idx, 2'b00});
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SIZE_OUTER:    walk_cfg.size_outer = val[SizeWidth-1:0];
         REG_SIZE_MIDDLE:   walk_cfg.size_middle = val[SizeWidth-1:0];
         REG_SIZE_INNER:    walk_cfg.size_inner = val[SizeWidth-1:0];
         REG_STRIDE_OUTER:  walk_cfg.stride_outer = val;
         REG_STRIDE_MIDDLE: walk_cfg.stride_middle = val;
         REG_STRIDE_INNER:  walk_cfg.stride_inner = val;
         REG_ELEMENT_BYTES: walk_cfg.element_bytes = val[EbWidth-1:0];
         REG_BASE_OFFSET:   walk_cfg.base_offset = val;
         default: ;
      endcase
   endtask

   // Unused upper data bits carry noise; the block keeps only the register width.
   task automatic program_shape(input bit [15:0] so, input bit [15:0] sm, input bit [15:0] si,
                                input bit [31:0] to, input bit [31:0] tm, input bit [31:0] ti,
                                input bit [3:0] eb, input bit [31:0] base);
      csr_write(REG_SIZE_OUTER, {16'($urandom), so});
      csr_write(REG_SIZE_MIDDLE, {16'($urandom), sm});
      csr_write(REG_SIZE_INNER, {16'($urandom), si});
      csr_write(REG_STRIDE_OUTER, to);
      csr_write(REG_STRIDE_MIDDLE, tm);
      csr_write(REG_STRIDE_INNER, ti);
      csr_write(REG_ELEMENT_BYTES, {28'($urandom), eb});
      csr_write(REG_BASE_OFFSET, base);
   endtask

   // Small extents mostly, so walks finish; some strides line up so that dimensions merge.
   task automatic random_shape();
      bit [63:0] run;
      bit [15:0] sz [NumDims];
      bit [31:0] st [NumDims];
      bit [3:0]  eb;
      int pick;
      run = 64'd1;
      for (int d = 0; d < NumDims; d++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            sz[d] = 16'd0;
         end else if (pick < 8) begin
            sz[d] = 16'hFFFF;
         end else begin
            sz[d] = 16'($urandom_range(1, 5));
         end
         pick = $urandom_range(0, 99);
         if (pick < 45 && run <= 64'hFFFF_FFFF) begin
            st[d] = run[31:0];
         end else if (pick < 55) begin
            st[d] = 32'd0;
         end else if (pick < 65) begin
            st[d] = 32'hFFFF_FFFF;
         end else if (pick < 85) begin
            st[d] = 32'($urandom_range(1, 64));
         end else begin
            st[d] = $urandom;
         end
         run = (run * ((sz[d] == 16'd0) ? 64'd1 : 64'(sz[d]))) & Mask48;
      end
      eb = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      program_shape(sz[2], sz[1], sz[0], st[2], st[1], st[0], eb, $urandom);
   endtask

   task automatic queue_items(input int n, input int restart_pct);
      for (int i = 0; i < n; i++) begin
         pending_restarts = {pending_restarts, bit'($urandom_range(0, 99) < restart_pct)};
      end
   endtask

   task automatic push_restarts(input bit [15:0] pattern, input int n);
      for (int i = 0; i < n; i++) begin
         pending_restarts = {pending_restarts, pattern[i]};
      end
   endtask

   task automatic drain();
      while (pending_restarts.size() != 0 || req_valid || expected_segments.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : drive_requests
      bit               fire;
      segment_desc_type next_seg;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         req_restart <= 1'b0;
      end else begin
         if (fire) begin
            next_seg = predict_segment(req_restart);
            expected_segments = {expected_segments, next_seg};
            tx_gap = draw_gap(tx_idle_on);
         end
         if (fire || !req_valid) begin
            if (tx_gap > 0 || pending_restarts.size() == 0) begin
               req_valid <= 1'b0;
               if (tx_gap > 0) begin
                  tx_gap--;
               end
            end else begin
               req_valid <= 1'b1;
               req_restart <= pending_restarts.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin : check_segments
      segment_desc_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_segments.size() == 0) begin
               report_error($sformatf("segment with no request waiting: src %h",
                                      rsp_src_byte_offset));
            end else begin
               want = expected_segments.pop_front();
               if (rsp_src_byte_offset !== want.src) begin
                  report_error($sformatf("src_byte_offset %h, expected %h",
                                         rsp_src_byte_offset, want.src));
               end
               if (rsp_dst_byte_offset !== want.dst) begin
                  report_error($sformatf("dst_byte_offset %h, expected %h",
                                         rsp_dst_byte_offset, want.dst));
               end
               if (rsp_segment_bytes !== want.seg) begin
                  report_error($sformatf("segment_bytes %h, expected %h",
                                         rsp_segment_bytes, want.seg));
               end
               if (rsp_last_segment !== want.last) begin
                  report_error($sformatf("last_segment %b, expected %b",
                                         rsp_last_segment, want.last));
               end
            end
         end
         if (rx_hold) begin
            rsp_stall <= 1'b1;
         end else if (rx_gap > 0) begin
            rsp_stall <= 1'b1;
            rx_gap--;
         end else begin
            rsp_stall <= 1'b0;
            rx_gap = draw_gap(rx_idle_on);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("strided_segment_address_generator_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      walk_cfg = '{size_outer: 16'd1, size_middle: 16'd1, size_inner: 16'd1,
                   stride_outer: 32'd1, stride_middle: 32'd1, stride_inner: 32'd1,
                   element_bytes: 4'd4, base_offset: 32'd0};
      for (int d = 0; d < NumDims; d++) begin
         digit[d] = 16'd0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset shape merges everything; a plain request with no walk starts one.
      push_restarts(16'b10, 2);
      drain();

      // Inner dimension merges, middle and outer are stepped; a request after the
      // last segment starts a new walk, then a restart arrives mid-walk.
      program_shape(16'd2, 16'd3, 16'd4, 32'd100, 32'd10, 32'd1, 4'd2, 32'd5);
      push_restarts(16'b1_0000_0001, 9);
      drain();

      // Register writes in the middle of a walk keep the merge and the digits.
      csr_write(REG_SIZE_MIDDLE, 32'd0);
      csr_write(REG_STRIDE_INNER, 32'd0);
      csr_write(REG_ELEMENT_BYTES, 32'd0);
      csr_write(REG_BASE_OFFSET, 32'hFFFF_FFFF);
      push_restarts(16'b000, 3);
      drain();

      // Largest extents, all merged into one huge segment.
      program_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFE_0001, 32'h0000_FFFF, 32'd1,
                    4'd15, 32'hFFFF_FFFF);
      push_restarts(16'b01, 2);
      drain();

      // Nothing merges; largest strides and a zero stride.
      program_shape(16'hFFFF, 16'd2, 16'd2, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                    4'd8, 32'hFFFF_FFFF);
      push_restarts(16'b00_0001, 6);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         tx_idle_on <= ($urandom_range(0, 3) != 0);
         rx_idle_on <= ($urandom_range(0, 3) != 0);
         random_shape();
         queue_items(60, (phase == 6) ? 35 : 4);
         drain();
      end

      // Receiver holds off while the sender keeps offering, so the block backs up.
      tx_idle_on <= 1'b0;
      rx_idle_on <= 1'b1;
      random_shape();
      queue_items(60, 4);
      rx_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rx_hold <= 1'b0;
      drain();

      repeat (10) @(posedge clock);
      if (expected_segments.size() != 0) begin
         report_error($sformatf("%0d segments never arrived", expected_segments.size()));
      end
      if (error_count == 0) begin
         $display("strided_segment_address_generator_tb: PASS");
      end else begin
         $display("strided_segment_address_generator_tb: FAIL");
      end
      $finish;
   end

endmodule
